### src/assert_macros.svh
// Assertion macros shared by the keyframe sampler RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

### src/ktsmp_pkg.sv
// Package for the keyframe track sampler: payload structs, controller
// states, command and status structs. No dependencies.
package ktsmp_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // remainder bits of the weight divide after the leading bit
    localparam int DIV_STEPS = 16;
    // shared multiplier: six products plus a final drain step
    localparam int MUL_STEPS = 7;
    localparam int CNT_W     = 5;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         key_slot;
        logic [31:0]        key_time;
        logic signed [31:0] key_value_x;
        logic signed [31:0] key_value_y;
        logic signed [31:0] key_value_z;
        logic [31:0]        elapsed;
    } item_t;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] sample_z;
        logic [6:0]         segment;
        logic               held_first;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_HOLD_RD,
        ST_HOLD_CAP,
        ST_VP_RD,
        ST_VC_RD,
        ST_V_CAP,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load_wr;
        logic       advance;
        logic       out_zero;
        logic       t_rd;
        logic       cap_prev;
        logic       v_rd;
        logic       cap_vp;
        logic       cap_vc;
        logic       hold_out;
        logic       div_init;
        logic       div_step;
        logic       mul_en;
        logic [2:0] mul_step;
        logic [6:0] seg;
    } ctl_cmd_t;

    typedef struct packed {
        logic clk_ge_time;
    } dp_status_t;

endpackage

### src/ktsmp_datapath.sv
// Datapath of the keyframe sampler: key memories, local clock, serial
// weight divider, shared multiplier and result registers. Uses ktsmp_pkg.
module ktsmp_datapath #(
    parameter int KEYS = 64,
    parameter int IW   = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ktsmp_pkg::item_t     item,
    input  ktsmp_pkg::ctl_cmd_t  cmd,
    input  logic [IW-1:0]        rd_addr,
    output ktsmp_pkg::dp_status_t status,
    output ktsmp_pkg::result_t   result
);
    import ktsmp_pkg::*;

    localparam int SW = (IW > 6) ? IW + 1 : 7;

    logic [31:0] key_times [KEYS];
    logic [95:0] key_values [KEYS];

    logic [31:0] clock_reg;
    logic [31:0] time_rd_reg;
    logic [95:0] val_rd_reg;
    logic [31:0] prev_time_reg;
    logic [95:0] vp_reg;
    logic [95:0] vc_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [16:0] q_reg;
    logic signed [48:0] prod_reg;
    logic signed [48:0] acc_reg;
    result_t     res_reg;

    logic        slot_ok;
    logic [32:0] clk_sum;
    logic [31:0] d_init;
    logic [31:0] den_init;
    logic [32:0] rem_shift;
    logic [16:0] mul_a;
    logic signed [31:0] mul_v;
    logic [1:0]  comp_in;
    logic [2:0]  step_out;
    logic [1:0]  comp_out;
    logic signed [48:0] acc_sum;

    assign slot_ok  = SW'(item.key_slot) < SW'(KEYS);
    assign clk_sum  = {1'b0, clock_reg} + {1'b0, item.elapsed};
    assign d_init   = time_rd_reg - clock_reg;
    assign den_init = time_rd_reg - prev_time_reg;
    assign rem_shift = {rem_reg[31:0], 1'b0};
    assign status.clk_ge_time = clock_reg >= time_rd_reg;

    // key memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && slot_ok)
        begin
            key_times[IW'(item.key_slot)]  <= item.key_time;
            key_values[IW'(item.key_slot)] <= {item.key_value_x, item.key_value_y,
                                               item.key_value_z};
        end
        if (cmd.t_rd)
            time_rd_reg <= key_times[rd_addr];
        if (cmd.v_rd)
            val_rd_reg <= key_values[rd_addr];
    end

    // saturating local clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_reg <= '0;
        else if (cmd.advance)
            clock_reg <= clk_sum[32] ? 32'hFFFF_FFFF : clk_sum[31:0];
    end

    // operand select for the shared multiplier; value words are x,y,z high to low
    always_comb
    begin
        comp_in = cmd.mul_step[2:1];
        mul_a = cmd.mul_step[0] ? (17'h10000 - q_reg) : q_reg;
        case (comp_in)
            2'd0:    mul_v = cmd.mul_step[0] ? vc_reg[95:64] : vp_reg[95:64];
            2'd1:    mul_v = cmd.mul_step[0] ? vc_reg[63:32] : vp_reg[63:32];
            default: mul_v = cmd.mul_step[0] ? vc_reg[31:0]  : vp_reg[31:0];
        endcase
        step_out = cmd.mul_step - 3'd1;
        comp_out = step_out[2:1];
        acc_sum  = acc_reg + prod_reg;
    end

    // divider, multiplier and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_prev)
            prev_time_reg <= time_rd_reg;
        if (cmd.cap_vp)
            vp_reg <= val_rd_reg;
        if (cmd.cap_vc)
            vc_reg <= val_rd_reg;

        // leading quotient bit is set only when the clock sits on the earlier key
        if (cmd.div_init)
        begin
            den_reg <= den_init;
            if (d_init >= den_init)
            begin
                rem_reg <= {1'b0, d_init - den_init};
                q_reg   <= 17'd1;
            end
            else
            begin
                rem_reg <= {1'b0, d_init};
                q_reg   <= 17'd0;
            end
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_reg <= rem_shift - {1'b0, den_reg};
                q_reg   <= {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                q_reg   <= {q_reg[15:0], 1'b0};
            end
        end

        if (cmd.mul_en)
        begin
            if (cmd.mul_step < 3'(MUL_STEPS - 1))
                prod_reg <= 49'($signed({1'b0, mul_a}) * mul_v);
            if (cmd.mul_step != 3'd0)
            begin
                if (!step_out[0])
                    acc_reg <= prod_reg;
                else
                begin
                    case (comp_out)
                        2'd0:    res_reg.sample_x <= acc_sum[47:16];
                        2'd1:    res_reg.sample_y <= acc_sum[47:16];
                        default: res_reg.sample_z <= acc_sum[47:16];
                    endcase
                    res_reg.segment    <= cmd.seg;
                    res_reg.held_first <= 1'b0;
                end
            end
        end
        else if (cmd.hold_out)
        begin
            res_reg.sample_x   <= val_rd_reg[95:64];
            res_reg.sample_y   <= val_rd_reg[63:32];
            res_reg.sample_z   <= val_rd_reg[31:0];
            res_reg.segment    <= '0;
            res_reg.held_first <= 1'b1;
        end
        else if (cmd.out_zero)
            res_reg <= '0;
    end

    assign result = res_reg;

endmodule

### src/ktsmp_ctrl.sv
// Controller of the keyframe sampler: key scan, divide and multiply
// sequencing. Uses ktsmp_pkg and assert_macros.svh.
module ktsmp_ctrl #(
    parameter int KEYS = 64,
    parameter int IW   = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  opcode,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_wdata,
    input  ktsmp_pkg::dp_status_t status,
    output logic                  busy,
    output logic                  done,
    output ktsmp_pkg::ctl_cmd_t   cmd,
    output logic [IW-1:0]         rd_addr
);
    import ktsmp_pkg::*;

    localparam int NW   = $clog2(KEYS + 1);
    localparam int CMPW = (NW > 7) ? NW : 7;
    localparam logic [CMPW-1:0] KEYS_C = CMPW'(KEYS);

    state_t              state_reg, state_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [6:0]          cfg_reg;

    logic                accept;
    logic [CMPW-1:0]     kiu_ext;
    logic [NW-1:0]       n_cfg;
    logic                last_key;

    assign accept   = start && !busy;
    assign kiu_ext  = CMPW'(cfg_reg);
    assign n_cfg    = NW'((kiu_ext > KEYS_C) ? KEYS_C : kiu_ext);
    assign last_key = ((NW + 1)'(i_reg) + (NW + 1)'(1)) >= (NW + 1)'(n_reg);

    // config register and sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            n_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            state_reg <= state_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_ADVANCE)
                begin
                    n_next = n_cfg;
                    i_next = '0;
                    state_next = (n_cfg == '0) ? ST_EMIT : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
                state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (status.clk_ge_time)
                begin
                    if (!last_key)
                    begin
                        i_next = i_reg + IW'(1);
                        state_next = ST_SCAN_RD;
                    end
                    else
                        state_next = ST_HOLD_RD;
                end
                else if (i_reg == '0)
                    state_next = ST_HOLD_RD;
                else
                    state_next = ST_VP_RD;
            end
            ST_HOLD_RD:
                state_next = ST_HOLD_CAP;
            ST_HOLD_CAP:
                state_next = ST_EMIT;
            ST_VP_RD:
                state_next = ST_VC_RD;
            ST_VC_RD:
                state_next = ST_V_CAP;
            ST_V_CAP:
            begin
                cnt_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_MUL;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_EMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands to the datapath; busy is low only in idle, so start alone accepts there
    always_comb
    begin
        cmd     = '0;
        rd_addr = i_reg;
        busy    = 1'b1;
        done    = 1'b0;
        cmd.seg = 7'(i_reg);
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_wr  = (opcode == OP_LOAD);
                    cmd.advance  = (opcode == OP_ADVANCE);
                    cmd.out_zero = (opcode == OP_ADVANCE) && (n_cfg == '0);
                end
            end
            ST_SCAN_RD:
                cmd.t_rd = 1'b1;
            ST_SCAN_CHK:
            begin
                cmd.cap_prev = status.clk_ge_time && !last_key;
                cmd.div_init = !status.clk_ge_time && (i_reg != '0);
            end
            ST_HOLD_RD:
            begin
                rd_addr  = '0;
                cmd.v_rd = 1'b1;
            end
            ST_HOLD_CAP:
                cmd.hold_out = 1'b1;
            ST_VP_RD:
            begin
                rd_addr  = i_reg - IW'(1);
                cmd.v_rd = 1'b1;
            end
            ST_VC_RD:
            begin
                cmd.v_rd   = 1'b1;
                cmd.cap_vp = 1'b1;
            end
            ST_V_CAP:
                cmd.cap_vc = 1'b1;
            ST_DIV:
                cmd.div_step = 1'b1;
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 3'(cnt_reg);
            end
            ST_EMIT:
                done = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_NEXT(a_adv_busy, clk, rst_n, accept && opcode == OP_ADVANCE, busy)
    `ASSERT_NEXT(a_load_quiet, clk, rst_n, accept && opcode == OP_LOAD, !busy && !done)

endmodule

### src/keyframe_track_sampler.sv
// Keyframe track sampler top level: key load, clock advance and sampling.
// Uses ktsmp_pkg, ktsmp_ctrl and ktsmp_datapath.
//
// Input channel: item is transferred at a clock edge with start high and
// busy low. A load item (opcode 0) writes one key's time and value at that
// edge and leaves busy low. An advance item (opcode 1) bumps the saturating
// local clock and produces one result.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall and must take it then.
// Config: cfg_we/cfg_wdata write keys_in_use. The user must write it only
// while the block is idle; the block itself has no check for this.
// An advance with no keys in use emits a zero result. Otherwise the keys
// are scanned, each by a registered read of the time memory and a compare,
// and then key 0 is held or the result interpolated. The weight comes from
// a 17-step serial divider and the blend from one shared 17x32 multiplier.
// Busy stays high from transfer through the done cycle.
// Reset clears the clock, keys_in_use and the sequencer; key memories are
// not cleared and must be loaded before being sampled.
module keyframe_track_sampler #(
    parameter int KEYS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ktsmp_pkg::item_t    item,
    output logic                done,
    output ktsmp_pkg::result_t  result,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata
);
    import ktsmp_pkg::*;

    localparam int IW = $clog2(KEYS);

    ctl_cmd_t       cmd;
    dp_status_t     status;
    logic [IW-1:0]  rd_addr;

    ktsmp_ctrl #(
        .KEYS (KEYS),
        .IW   (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (item.opcode),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    ktsmp_datapath #(
        .KEYS (KEYS),
        .IW   (IW)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .status  (status),
        .result  (result)
    );

endmodule
